>>> sv/timed_dimmer_ramp_assert.svh
// Assertion macros shared by the dimmer ramp RTL.
`ifndef TIMED_DIMMER_RAMP_ASSERT_SVH
`define TIMED_DIMMER_RAMP_ASSERT_SVH

// Condition must hold on every clock edge out of reset.
`define TDR_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TDR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define TDR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> sv/tdr_pkg.sv
// Package for the dimmer ramp: constants, codes and interface types.
`timescale 1ns / 1ps

package tdr_pkg;

	localparam int TDR_FULL_SCALE    = 10000;
	localparam int TDR_FRACTION_BITS = 8;

	localparam int DATA_W  = 16;
	localparam int LEVEL_W = 32;
	localparam int STEP_W  = 22;
	localparam int LVL_W   = 16;
	localparam int PCT_W   = 10;
	localparam int TGT_W   = 7;
	localparam int OUT_W   = 14;
	localparam int OPCT_W  = 7;

	localparam logic [STEP_W-1:0] STEP_MAX   = 22'h3F_FFFF;
	localparam logic [DATA_W-1:0] PCT_MAX    = 16'd100;
	localparam logic [TGT_W-1:0]  PCT_SCALE  = 7'd100;
	localparam logic [DATA_W-1:0] TIME_RESET = 16'd1000;

	typedef enum logic [1:0] {
		ACT_TICK   = 2'd0,
		ACT_TARGET = 2'd1,
		ACT_TIME   = 2'd2
	} tdr_action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UP,
		ST_DN,
		ST_PCT_START,
		ST_PCT_DIV,
		ST_WPREP,
		ST_STEP_DIV,
		ST_FINISH
	} tdr_state_t;

	typedef struct packed {
		logic up;
		logic dn;
	} tdr_lvl_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} tdr_div_stat_t;

endpackage

>>> sv/timed_dimmer_ramp.sv
// Top level of the lamp dimmer ramp: control sequencer, settings and result register.
`timescale 1ns / 1ps

// Lamp dimmer ramp generator. Each input transaction is a 1 ms tick (action 0), a target
// percent write (action 1) or a ramp time write in ms (action 2); action 3 changes nothing.
// Every transaction returns exactly one result transaction with the duty level (0..FULL_SCALE),
// the inverted timer compare value and the integer level percent. A write with a nonzero ramp
// time clamps the target to 100 and recomputes the step as |percent - target|*100/time in
// Q.FRACTION_BITS; with zero time the value is just stored. A tick first steps up toward
// target*100, then steps down if above, so the level may dither around the target.
// One transaction at a time: the next is accepted only once the last result is written. A
// tick steps up, steps down, then divides the level for the percent; a write with nonzero
// time divides for the step, while a zero-time write and action 3 go straight to the result.
// The bit-serial divider produces one quotient bit per cycle and serves both the percent
// readout and the step recompute. A finished result sits in the output register, and the
// next transaction is worked on while it waits; only the final write of that next result
// stalls on a full output register.
`include "timed_dimmer_ramp_assert.svh"

module timed_dimmer_ramp #(
	parameter int FULL_SCALE    = tdr_pkg::TDR_FULL_SCALE,
	parameter int FRACTION_BITS = tdr_pkg::TDR_FRACTION_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  action,
	input  logic [tdr_pkg::DATA_W-1:0]  data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tdr_pkg::OUT_W-1:0]   duty_compare,
	output logic [tdr_pkg::OUT_W-1:0]   output_level,
	output logic [tdr_pkg::OPCT_W-1:0]  level_percent
);

	localparam int GOAL_W = 23 + FRACTION_BITS;
	localparam int NUM_W  = 17 + FRACTION_BITS;
	localparam int SAT_W  = (NUM_W > tdr_pkg::STEP_W) ? NUM_W : tdr_pkg::STEP_W;

	tdr_pkg::tdr_state_t state_q, state_d;

	// settings and ramp state
	logic [tdr_pkg::DATA_W-1:0] target_q;
	logic [tdr_pkg::DATA_W-1:0] time_q;
	logic [tdr_pkg::STEP_W-1:0] step_q;
	logic [tdr_pkg::PCT_W-1:0]  percent_q;
	logic [GOAL_W-1:0]          goal_q;

	// result register
	logic                       out_valid_q;
	logic [tdr_pkg::OUT_W-1:0]  duty_q;
	logic [tdr_pkg::OUT_W-1:0]  level_q;
	logic [tdr_pkg::OPCT_W-1:0] pct_out_q;

	// sequencer strobes
	logic                  accept;
	logic                  div_start;
	logic                  div_for_step;
	logic                  out_load;
	tdr_pkg::tdr_lvl_cmd_t lvl_cmd;

	// datapath
	logic [tdr_pkg::LVL_W-1:0]  lvl;
	logic [tdr_pkg::TGT_W-1:0]  tgt_clamp;
	logic [tdr_pkg::PCT_W-1:0]  pct_diff;
	logic [16:0]                diff100;
	logic [NUM_W-1:0]           div_num;
	logic [tdr_pkg::DATA_W-1:0] div_den;
	logic [NUM_W-1:0]           quot;
	tdr_pkg::tdr_div_stat_t     div_stat;
	logic [tdr_pkg::LVL_W-1:0]  duty_full;

	tdr_level #(
		.FULL_SCALE    (FULL_SCALE),
		.FRACTION_BITS (FRACTION_BITS)
	) u_level (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (lvl_cmd),
		.goal   (goal_q),
		.step   (step_q),
		.lvl    (lvl)
	);

	tdr_serdiv #(
		.NUM_W (NUM_W),
		.DEN_W (tdr_pkg::DATA_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat),
		.quot   (quot)
	);

	// divider operands: step dividend |percent - clamped target| * 100 in fixed point, else the level over 100
	always_comb begin
		tgt_clamp = (target_q > tdr_pkg::PCT_MAX) ? tdr_pkg::PCT_MAX[tdr_pkg::TGT_W-1:0]
		                                          : target_q[tdr_pkg::TGT_W-1:0];
		pct_diff  = (percent_q > tdr_pkg::PCT_W'(tgt_clamp))
		          ? percent_q - tdr_pkg::PCT_W'(tgt_clamp)
		          : tdr_pkg::PCT_W'(tgt_clamp) - percent_q;
		diff100   = 17'(pct_diff) * 17'(tdr_pkg::PCT_SCALE);
		if (div_for_step) begin
			div_num = NUM_W'(diff100) << FRACTION_BITS;
			div_den = time_q;
		end else begin
			div_num = NUM_W'(lvl);
			div_den = tdr_pkg::DATA_W'(tdr_pkg::PCT_SCALE);
		end
		duty_full = tdr_pkg::LVL_W'(FULL_SCALE) - lvl;
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tdr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		div_start    = 1'b0;
		div_for_step = 1'b0;
		out_load     = 1'b0;
		lvl_cmd      = '0;
		unique case (state_q)
			tdr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (action) inside
						tdr_pkg::ACT_TICK:                    state_d = tdr_pkg::ST_UP;
						tdr_pkg::ACT_TARGET, tdr_pkg::ACT_TIME: state_d = tdr_pkg::ST_WPREP;
						default:                              state_d = tdr_pkg::ST_FINISH;
					endcase
				end
			end
			tdr_pkg::ST_UP: begin
				lvl_cmd.up = 1'b1;
				state_d    = tdr_pkg::ST_DN;
			end
			tdr_pkg::ST_DN: begin
				lvl_cmd.dn = 1'b1;
				state_d    = tdr_pkg::ST_PCT_START;
			end
			tdr_pkg::ST_PCT_START: begin
				div_start = 1'b1;
				state_d   = tdr_pkg::ST_PCT_DIV;
			end
			tdr_pkg::ST_PCT_DIV: begin
				if (div_stat.done) begin
					state_d = tdr_pkg::ST_FINISH;
				end
			end
			tdr_pkg::ST_WPREP: begin
				div_for_step = 1'b1;
				if (time_q == '0) begin
					state_d = tdr_pkg::ST_FINISH;
				end else begin
					div_start = 1'b1;
					state_d   = tdr_pkg::ST_STEP_DIV;
				end
			end
			tdr_pkg::ST_STEP_DIV: begin
				if (div_stat.done) begin
					state_d = tdr_pkg::ST_FINISH;
				end
			end
			tdr_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = tdr_pkg::ST_IDLE;
				end
			end
			default: state_d = tdr_pkg::ST_IDLE;
		endcase
	end

	// settings, step and cached percent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= '0;
			time_q    <= tdr_pkg::TIME_RESET;
			step_q    <= '0;
			percent_q <= '0;
		end else begin
			if (accept && action == tdr_pkg::ACT_TARGET) begin
				target_q <= data;
			end
			if (accept && action == tdr_pkg::ACT_TIME) begin
				time_q <= data;
			end
			if (state_q == tdr_pkg::ST_WPREP && time_q != '0) begin
				target_q <= tdr_pkg::DATA_W'(tgt_clamp);
			end
			if (state_q == tdr_pkg::ST_STEP_DIV && div_stat.done) begin
				step_q <= (SAT_W'(quot) > SAT_W'(tdr_pkg::STEP_MAX)) ? tdr_pkg::STEP_MAX
				                                                     : tdr_pkg::STEP_W'(quot);
			end
			// percent of the level, kept current for the next step recompute
			if (state_q == tdr_pkg::ST_PCT_DIV && div_stat.done) begin
				percent_q <= tdr_pkg::PCT_W'(quot);
			end
		end
	end

	// goal = target * 100 in fixed point, latched for the tick
	always_ff @(posedge clk) begin
		if (accept) begin
			goal_q <= GOAL_W'(23'(target_q) * 23'(tdr_pkg::PCT_SCALE)) << FRACTION_BITS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			duty_q    <= duty_full[tdr_pkg::OUT_W-1:0];
			level_q   <= lvl[tdr_pkg::OUT_W-1:0];
			pct_out_q <= percent_q[tdr_pkg::OPCT_W-1:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign duty_compare  = duty_q;
	assign output_level  = level_q;
	assign level_percent = pct_out_q;

	`TDR_ASSERT_NEXT(a_one_at_a_time, accept, !in_ready, "transaction accepted while busy")
	`TDR_ASSERT_SAME(a_idle_div_quiet, state_q == tdr_pkg::ST_IDLE, !div_stat.busy, "divider busy in idle")
	`TDR_ASSERT_SAME(a_done_expected, div_stat.done, state_q == tdr_pkg::ST_PCT_DIV || state_q == tdr_pkg::ST_STEP_DIV, "divider done outside a wait state")
	`TDR_ASSERT_NEXT(a_zero_time_keeps_step, state_q == tdr_pkg::ST_WPREP && time_q == '0, $stable(step_q), "step changed with zero ramp time")
	`TDR_ASSERT_ALWAYS(a_level_in_range, lvl <= tdr_pkg::LVL_W'(FULL_SCALE), "level above full scale")

endmodule

>>> sv/tdr_serdiv.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module tdr_serdiv #(
	parameter int NUM_W = 25,
	parameter int DEN_W = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [NUM_W-1:0]      num,
	input  logic [DEN_W-1:0]      den,
	output tdr_pkg::tdr_div_stat_t stat,
	output logic [NUM_W-1:0]      quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W+1:0] trial;
	logic             fits;

	// shifted remainder minus divisor; top bit is the borrow
	assign trial = {1'b0, rem_q, num_q[NUM_W-1]} - {2'b00, den_q};
	assign fits  = ~trial[DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], fits};
			rem_q <= fits ? trial[DEN_W-1:0] : {rem_q[DEN_W-2:0], num_q[NUM_W-1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = num_q;

endmodule

>>> sv/tdr_level.sv
// Ramp level register with saturating step up/down and duty readout.
`timescale 1ns / 1ps

module tdr_level #(
	parameter int FULL_SCALE    = tdr_pkg::TDR_FULL_SCALE,
	parameter int FRACTION_BITS = tdr_pkg::TDR_FRACTION_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tdr_pkg::tdr_lvl_cmd_t           cmd,
	input  logic [23+FRACTION_BITS-1:0]     goal,
	input  logic [tdr_pkg::STEP_W-1:0]      step,
	output logic [tdr_pkg::LVL_W-1:0]       lvl
);

	localparam int GOAL_W = 23 + FRACTION_BITS;
	localparam int EXTW   = (GOAL_W + 1 > 34) ? GOAL_W + 1 : 34;
	localparam int LW     = tdr_pkg::LEVEL_W;

	localparam logic [EXTW-1:0] LMAX_X = {{(EXTW-LW){1'b0}}, 32'h7FFF_FFFF};
	localparam logic [EXTW-1:0] LMIN_X = {{(EXTW-LW){1'b1}}, 32'h8000_0000};

	logic [LW-1:0]   ramp_level_q;
	logic [EXTW-1:0] level_x;
	logic [EXTW-1:0] goal_x;
	logic [EXTW-1:0] step_x;
	logic [EXTW-1:0] sum_x;
	logic [EXTW-1:0] dif_x;
	logic [LW-1:0]   shifted;

	always_comb begin
		level_x = {{(EXTW-LW){ramp_level_q[LW-1]}}, ramp_level_q};
		goal_x  = EXTW'(goal);
		step_x  = EXTW'(step);
		sum_x   = level_x + step_x;
		dif_x   = level_x - step_x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_level_q <= '0;
		end else if (cmd.up && ($signed(level_x) < $signed(goal_x))) begin
			ramp_level_q <= ($signed(sum_x) > $signed(LMAX_X)) ? LMAX_X[LW-1:0] : sum_x[LW-1:0];
		end else if (cmd.dn && ($signed(level_x) > $signed(goal_x))) begin
			ramp_level_q <= ($signed(dif_x) < $signed(LMIN_X)) ? LMIN_X[LW-1:0] : dif_x[LW-1:0];
		end
	end

	// integer part, negative reads as zero, clamped to full scale
	always_comb begin
		shifted = ramp_level_q >> FRACTION_BITS;
		if (ramp_level_q[LW-1]) begin
			lvl = '0;
		end else if (shifted > LW'(FULL_SCALE)) begin
			lvl = tdr_pkg::LVL_W'(FULL_SCALE);
		end else begin
			lvl = shifted[tdr_pkg::LVL_W-1:0];
		end
	end

endmodule

>>> dv/timed_dimmer_ramp_tb.sv
// Self-checking testbench for the lamp dimmer ramp: directed corner cases, then random traffic.
`timescale 1ns / 1ps

module timed_dimmer_ramp_tb;

	// action code 3 has no package name; the block must treat it as a no-op
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	// time limit in ns for the whole run, after which the watchdog fails it
	localparam longint RUN_LIMIT_NS = 64'd5_000_000;
	// drain margin after the last result
	localparam int DRAIN_CYCLES = 64;

	typedef struct packed {
		logic [tdr_pkg::OUT_W-1:0]  compare;
		logic [tdr_pkg::OUT_W-1:0]  level;
		logic [tdr_pkg::OPCT_W-1:0] percent;
	} duty_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [1:0]                 action = 2'd0;
	logic [tdr_pkg::DATA_W-1:0] data = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [tdr_pkg::OUT_W-1:0]  duty_compare;
	logic [tdr_pkg::OUT_W-1:0]  output_level;
	logic [tdr_pkg::OPCT_W-1:0] level_percent;

	// shadow of the dimmer state, Q.8 level in 1/100 percent units
	int                         lamp_acc;
	logic [tdr_pkg::STEP_W-1:0] lamp_rate;
	logic [tdr_pkg::DATA_W-1:0] goal_pct;
	logic [tdr_pkg::DATA_W-1:0] fade_ms;

	duty_t expected_duty[$];
	int    fail_count = 0;

	// idling knobs, in percent of cycles
	int in_idle_pct = 0;
	int out_stall_pct = 0;

	timed_dimmer_ramp dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.data         (data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.duty_compare (duty_compare),
		.output_level (output_level),
		.level_percent(level_percent)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	// Level seen at the output: negative reads 0, fraction dropped, capped at full scale.
	function automatic logic [tdr_pkg::OUT_W-1:0] lamp_level();
		logic [31:0] whole;
		if (lamp_acc < 0)
			return '0;
		whole = lamp_acc >>> tdr_pkg::TDR_FRACTION_BITS;
		if (whole > tdr_pkg::TDR_FULL_SCALE)
			whole = tdr_pkg::TDR_FULL_SCALE;
		return whole[tdr_pkg::OUT_W-1:0];
	endfunction

	function automatic int sat_level(input longint v);
		if (v > longint'(32'sh7FFF_FFFF))
			return 32'sh7FFF_FFFF;
		if (v < longint'(32'sh8000_0000))
			return 32'sh8000_0000;
		return int'(v);
	endfunction

	// Step = |percent now - target| * 100 / ms, in Q.8. Zero time leaves everything alone,
	// including an out-of-range target.
	function automatic void refresh_rate();
		int unsigned     pct_now;
		int unsigned     gap;
		longint unsigned quot;
		if (fade_ms == 0)
			return;
		if (goal_pct > tdr_pkg::PCT_MAX)
			goal_pct = tdr_pkg::PCT_MAX;
		pct_now = lamp_level() / tdr_pkg::PCT_SCALE;
		gap = (pct_now > goal_pct) ? pct_now - goal_pct : goal_pct - pct_now;
		quot = ((longint'(gap) * tdr_pkg::PCT_SCALE) << tdr_pkg::TDR_FRACTION_BITS) / fade_ms;
		lamp_rate = (quot > tdr_pkg::STEP_MAX) ? tdr_pkg::STEP_MAX : quot[tdr_pkg::STEP_W-1:0];
	endfunction

	// One ms tick: step up if below the goal, then step down if (now) above it.
	function automatic void ramp_tick();
		longint goal;
		goal = (longint'(goal_pct) * tdr_pkg::PCT_SCALE) << tdr_pkg::TDR_FRACTION_BITS;
		if (longint'(lamp_acc) < goal)
			lamp_acc = sat_level(longint'(lamp_acc) + longint'(lamp_rate));
		if (longint'(lamp_acc) > goal)
			lamp_acc = sat_level(longint'(lamp_acc) - longint'(lamp_rate));
	endfunction

	function automatic void apply_dimmer_item(input logic [1:0] act,
	                                          input logic [tdr_pkg::DATA_W-1:0] val);
		duty_t                     d;
		logic [tdr_pkg::OUT_W-1:0] lvl;
		case (act)
			tdr_pkg::ACT_TICK: begin
				ramp_tick();
			end
			tdr_pkg::ACT_TARGET: begin
				goal_pct = val;
				refresh_rate();
			end
			tdr_pkg::ACT_TIME: begin
				fade_ms = val;
				refresh_rate();
			end
			default: begin
			end
		endcase
		lvl = lamp_level();
		d.compare = tdr_pkg::OUT_W'(tdr_pkg::TDR_FULL_SCALE - int'(lvl));
		d.level   = lvl;
		d.percent = tdr_pkg::OPCT_W'(lvl / tdr_pkg::PCT_SCALE);
		expected_duty.push_back(d);
	endfunction

	// ---------------------------------------------------------------
	// Monitor: inputs feed the predictor, results are checked in order.
	// Both handshakes are sampled at the edge, before any NBA lands.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				apply_dimmer_item(action, data);
			if (out_valid && out_ready) begin
				if (expected_duty.size() == 0) begin
					$error("result transaction with nothing expected");
					fail_count++;
				end else begin
					duty_t e;
					e = expected_duty.pop_front();
					if (duty_compare !== e.compare) begin
						$error("duty_compare expected %0d actual %0d", e.compare, duty_compare);
						fail_count++;
					end
					if (output_level !== e.level) begin
						$error("output_level expected %0d actual %0d", e.level, output_level);
						fail_count++;
					end
					if (level_percent !== e.percent) begin
						$error("level_percent expected %0d actual %0d", e.percent, level_percent);
						fail_count++;
					end
				end
			end
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= out_stall_pct);
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------

	// Present one transaction and hold it until accepted. Valid is only dropped for an
	// idle gap, never in the step where the next item goes out.
	task automatic send_item(input logic [1:0] act, input logic [tdr_pkg::DATA_W-1:0] val);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		data     <= val;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// level zero straight out of reset, for a tick and for an unused code
	task automatic test_reset_readout();
		send_item(tdr_pkg::ACT_TICK, 16'h0000);
		send_item(ACT_UNUSED, 16'h0000);
	endtask

	// Full swing in one tick, then a drop to exactly 1%, then with zero time the
	// kept step drives the level negative; the following tick adds and subtracts.
	task automatic test_swing_and_undershoot();
		send_item(tdr_pkg::ACT_TIME, 16'd1);
		send_item(tdr_pkg::ACT_TARGET, 16'd100);
		send_item(tdr_pkg::ACT_TICK, 16'hFFFF);
		send_item(tdr_pkg::ACT_TARGET, 16'd1);
		send_item(tdr_pkg::ACT_TICK, 16'h0000);
		send_item(tdr_pkg::ACT_TIME, 16'd0);
		send_item(tdr_pkg::ACT_TARGET, 16'd0);
		send_item(tdr_pkg::ACT_TICK, 16'h0000);
		send_item(tdr_pkg::ACT_TICK, 16'h0000);
	endtask

	// zero time keeps an out-of-range target; the level runs past full scale
	task automatic test_unclamped_target();
		send_item(tdr_pkg::ACT_TARGET, 16'hFFFF);
		repeat (3) send_item(tdr_pkg::ACT_TICK, 16'h0000);
	endtask

	// longest ramp time: target clamp on the time write, then a tiny step
	task automatic test_slow_ramp();
		send_item(tdr_pkg::ACT_TIME, 16'hFFFF);
		send_item(tdr_pkg::ACT_TARGET, 16'd0);
		send_item(tdr_pkg::ACT_TICK, 16'h0000);
	endtask

	task automatic test_unused_action();
		send_item(ACT_UNUSED, 16'hFFFF);
		send_item(ACT_UNUSED, 16'h0000);
	endtask

	// Mostly ticks, so ramps actually run between writes; short times keep steps
	// large enough to reach and dither around targets.
	task automatic test_random(input int count, input int idle_pct, input int stall_pct);
		int                         pick;
		int                         sel;
		logic [1:0]                 act;
		logic [tdr_pkg::DATA_W-1:0] val;
		in_idle_pct   = idle_pct;
		out_stall_pct = stall_pct;
		repeat (count) begin
			pick = $urandom_range(99);
			sel  = $urandom_range(19);
			val  = tdr_pkg::DATA_W'($urandom);
			if (pick < 70) begin
				act = tdr_pkg::ACT_TICK;
			end else if (pick < 83) begin
				act = tdr_pkg::ACT_TARGET;
				if (sel != 0)
					val = tdr_pkg::DATA_W'($urandom_range(100));
			end else if (pick < 95) begin
				act = tdr_pkg::ACT_TIME;
				if (sel == 0)
					val = '0;
				else if (sel > 2)
					val = tdr_pkg::DATA_W'($urandom_range(60, 1));
			end else begin
				act = ACT_UNUSED;
			end
			send_item(act, val);
		end
	endtask

	initial begin
		lamp_acc  = 0;
		lamp_rate = '0;
		goal_pct  = '0;
		fade_ms   = tdr_pkg::TIME_RESET;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_readout();
		test_swing_and_undershoot();
		test_unclamped_target();
		test_slow_ramp();
		test_unused_action();

		test_random(420, 0, 0);
		test_random(410, 50, 0);
		test_random(410, 0, 50);
		test_random(410, 11, 11);

		in_valid <= 1'b0;
		while (expected_duty.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && expected_duty.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// watchdog: a hung handshake ends the run as a failure
	initial begin
		#(RUN_LIMIT_NS);
		$display("status: fail");
		$finish;
	end

endmodule
